/* sv/esd_pkg.sv */
package esd_pkg;

    // Character codes used by the decoder.
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_SEVEN     = 8'h37;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_V         = 8'h76;
    localparam logic [7:0] CH_B         = 8'h62;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_F         = 8'h66;

    // Control bytes that the simple escapes stand for.
    localparam logic [7:0] BYTE_LF  = 8'h0A;
    localparam logic [7:0] BYTE_TAB = 8'h09;
    localparam logic [7:0] BYTE_VT  = 8'h0B;
    localparam logic [7:0] BYTE_BS  = 8'h08;
    localparam logic [7:0] BYTE_CR  = 8'h0D;
    localparam logic [7:0] BYTE_FF  = 8'h0C;

    // Error codes.
    localparam logic ERR_BAD_ESCAPE   = 1'b0;
    localparam logic ERR_UNTERMINATED = 1'b1;

    // Default depth of the queue between the front and the back part.
    localparam int QUEUE_DEPTH_DEF = 4;

    typedef enum logic [3:0] {
        MODE_NORMAL    = 4'b0001,
        MODE_BACKSLASH = 4'b0010,
        MODE_OCTAL1    = 4'b0100,
        MODE_OCTAL2    = 4'b1000
    } mode_t;

    typedef struct packed {
        logic [7:0] byte_out;
        logic       byte_valid;
        logic       error_flag;
        logic       error_code;
        logic       string_done;
    } res_t;

    // Results caused by one input character: one or two.
    typedef struct packed {
        res_t r0;
        res_t r1;
        logic two;
    } pkt_t;

    function automatic res_t mk_byte(input logic [7:0] b);
        res_t r;
        r = '0;
        r.byte_out   = b;
        r.byte_valid = 1'b1;
        return r;
    endfunction

    function automatic res_t mk_err(input logic code);
        res_t r;
        r = '0;
        r.error_flag = 1'b1;
        r.error_code = code;
        return r;
    endfunction

    // Returns {known, byte} for the character after a backslash.
    function automatic logic [8:0] esc_map(input logic [7:0] c);
        logic [8:0] v;
        v = '0;
        unique case (c)
            CH_BACKSLASH: v = {1'b1, CH_BACKSLASH};
            CH_N:         v = {1'b1, BYTE_LF};
            CH_T:         v = {1'b1, BYTE_TAB};
            CH_V:         v = {1'b1, BYTE_VT};
            CH_B:         v = {1'b1, BYTE_BS};
            CH_R:         v = {1'b1, BYTE_CR};
            CH_F:         v = {1'b1, BYTE_FF};
            default:      v = '0;
        endcase
        return v;
    endfunction

endpackage

/* sv/esd_front.sv */
module esd_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [7:0]    char_in,
    input  logic          end_of_string,
    input  logic          queue_full,
    output logic          push,
    output esd_pkg::pkt_t push_pkt
);
    import esd_pkg::*;

    mode_t       mode_reg;
    mode_t       mode_next;
    logic [8:0]  acc_reg;
    logic [8:0]  acc_next;
    logic        disc_reg;
    logic        disc_next;
    logic        accept;
    logic        is_oct;
    logic [2:0]  digit;
    logic [8:0]  shifted;
    logic [8:0]  esc_v;
    logic        failed;
    logic [1:0]  cnt;
    res_t        res_v [2];

    assign in_stall = queue_full;
    assign accept   = in_valid && !queue_full;
    assign is_oct   = (char_in >= CH_ZERO) && (char_in <= CH_SEVEN);
    assign digit    = char_in[2:0];
    assign shifted  = {acc_reg[5:0], digit};
    assign esc_v    = esc_map(char_in);

    always_comb
    begin
        mode_next = mode_reg;
        acc_next  = acc_reg;
        disc_next = disc_reg;
        failed    = 1'b0;
        cnt       = 2'd0;
        res_v[0]  = '0;
        res_v[1]  = '0;
        if (disc_reg)
        begin
            // The rest of a failed string is dropped; its end gives a marker.
            if (end_of_string)
            begin
                cnt = 2'd1;
            end
        end
        else
        begin
            unique case (mode_reg)
                MODE_NORMAL:
                begin
                    if (char_in == CH_BACKSLASH)
                    begin
                        mode_next = MODE_BACKSLASH;
                    end
                    else
                    begin
                        res_v[0] = mk_byte(char_in);
                        cnt      = 2'd1;
                    end
                end
                MODE_OCTAL1, MODE_OCTAL2:
                begin
                    if (is_oct && mode_reg == MODE_OCTAL1)
                    begin
                        acc_next  = shifted;
                        mode_next = MODE_OCTAL2;
                    end
                    else if (is_oct)
                    begin
                        // Third digit: a value above 255 is dropped silently.
                        acc_next  = shifted;
                        mode_next = MODE_NORMAL;
                        if (!shifted[8])
                        begin
                            res_v[0] = mk_byte(shifted[7:0]);
                            cnt      = 2'd1;
                        end
                    end
                    else
                    begin
                        // Run cut short: emit the value, then decode the
                        // ending character as a normal one.
                        res_v[0]  = mk_byte(acc_reg[7:0]);
                        cnt       = 2'd1;
                        mode_next = MODE_NORMAL;
                        if (char_in == CH_BACKSLASH)
                        begin
                            mode_next = MODE_BACKSLASH;
                        end
                        else
                        begin
                            res_v[1] = mk_byte(char_in);
                            cnt      = 2'd2;
                        end
                    end
                end
                MODE_BACKSLASH:
                begin
                    mode_next = MODE_NORMAL;
                    if (is_oct)
                    begin
                        acc_next  = {6'd0, digit};
                        mode_next = MODE_OCTAL1;
                    end
                    else if (esc_v[8])
                    begin
                        res_v[0] = mk_byte(esc_v[7:0]);
                        cnt      = 2'd1;
                    end
                    else
                    begin
                        res_v[0]  = mk_err(ERR_BAD_ESCAPE);
                        cnt       = 2'd1;
                        failed    = 1'b1;
                        disc_next = 1'b1;
                    end
                end
                default:
                begin
                    mode_next = MODE_NORMAL;
                end
            endcase

            if (end_of_string)
            begin
                if (!failed)
                begin
                    if (mode_next == MODE_BACKSLASH)
                    begin
                        res_v[cnt[0]] = mk_err(ERR_UNTERMINATED);
                        cnt           = cnt + 2'd1;
                    end
                    else if (mode_next == MODE_OCTAL1 || mode_next == MODE_OCTAL2)
                    begin
                        res_v[cnt[0]] = mk_byte(acc_next[7:0]);
                        cnt           = cnt + 2'd1;
                    end
                end
                if (cnt == 2'd0)
                begin
                    cnt = 2'd1;
                end
            end
        end

        if (end_of_string)
        begin
            res_v[cnt[1]].string_done = 1'b1;
            mode_next = MODE_NORMAL;
            acc_next  = '0;
            disc_next = 1'b0;
        end
    end

    assign push         = accept && (cnt != 2'd0);
    assign push_pkt.r0  = res_v[0];
    assign push_pkt.r1  = res_v[1];
    assign push_pkt.two = cnt[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_NORMAL;
            acc_reg  <= '0;
            disc_reg <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            disc_reg <= disc_next;
        end
    end

`ifndef SYNTHESIS
    a_eos_clears_state: assert property (@(posedge clk) disable iff (!rst_n)
        accept && end_of_string |=> mode_reg == MODE_NORMAL && !disc_reg)
        else $error("decoder state not cleared after end of string");
`endif

endmodule

/* sv/esd_fifo.sv */
module esd_fifo #(
    parameter int DEPTH = esd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  esd_pkg::pkt_t push_pkt,
    input  logic          pop,
    output logic          full,
    output logic          head_valid,
    output esd_pkg::pkt_t head_pkt
);
    import esd_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    pkt_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_pkt   = mem[rd_ptr_reg];

    assign wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

    always_comb
    begin
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_pkt;
        end
    end

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue written while full");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("queue read while empty");
`endif

endmodule

/* sv/esd_back.sv */
module esd_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          head_valid,
    input  esd_pkg::pkt_t head_pkt,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [7:0]    byte_out,
    output logic          byte_valid,
    output logic          error_flag,
    output logic          error_code,
    output logic          string_done
);
    import esd_pkg::*;

    logic sel_reg;
    logic sel_next;
    logic out_valid_reg;
    logic out_valid_next;
    res_t out_reg;
    res_t cur;
    logic load;

    assign cur  = sel_reg ? head_pkt.r1 : head_pkt.r0;
    assign load = head_valid && (!out_valid_reg || !out_stall);
    assign pop  = load && (sel_reg || !head_pkt.two);

    assign sel_next       = load ? (!sel_reg && head_pkt.two) : sel_reg;
    assign out_valid_next = load || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sel_reg       <= sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg <= cur;
        end
    end

    assign out_valid   = out_valid_reg;
    assign byte_out    = out_reg.byte_out;
    assign byte_valid  = out_reg.byte_valid;
    assign error_flag  = out_reg.error_flag;
    assign error_code  = out_reg.error_code;
    assign string_done = out_reg.string_done;

`ifndef SYNTHESIS
    a_second_needs_pair: assert property (@(posedge clk) disable iff (!rst_n)
        sel_reg |-> head_valid && head_pkt.two)
        else $error("second result selected without a two-result entry");

    a_byte_or_error: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(byte_valid && error_flag))
        else $error("result carries both a byte and an error");
`endif

endmodule

/* sv/escape_sequence_decoder.sv */
// Escape sequence decoder: takes one character per transfer on the input
// channel, with end_of_string on the last character of each string, and
// turns C-style escapes into bytes. A backslash followed by n, t, v, b, r, f
// or a backslash gives the matching control byte, and a backslash followed
// by one to three octal digits gives their value; a three-digit value above
// 255 produces no byte at all. An unknown escape, or a backslash as the last
// character, produces an error result, and the rest of that string is then
// dropped. Every string ends with exactly one result that has string_done
// set; if nothing else is due, that result is an empty marker. The block
// accepts one character every cycle while the queue is not full. A character
// produces zero, one or two results, and the output sends one result per
// cycle while out_stall is low, so a character that ends an octal run and
// is itself emitted yields two results. A front decoder classifies
// characters and queues their results in a small queue (QUEUE_DEPTH entries,
// each holding all results of one character), which stalls the input only
// when it is full; the back part drains the queue through a registered
// output. Each result passes a queue entry and then the output register.
module escape_sequence_decoder #(
    parameter int QUEUE_DEPTH = esd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] char_in,
    input  logic       end_of_string,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] byte_out,
    output logic       byte_valid,
    output logic       error_flag,
    output logic       error_code,
    output logic       string_done
);
    import esd_pkg::*;

    logic queue_full;
    logic push;
    pkt_t push_pkt;
    logic pop;
    logic head_valid;
    pkt_t head_pkt;

    // Front part: the decoding state machine, one character per cycle while the queue is not full.
    esd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .char_in       (char_in),
        .end_of_string (end_of_string),
        .queue_full    (queue_full),
        .push          (push),
        .push_pkt      (push_pkt)
    );

    // Queue that decouples decoding from output back pressure.
    esd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_pkt   (push_pkt),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_pkt   (head_pkt)
    );

    // Back part: sends the queued results one at a time.
    esd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_pkt    (head_pkt),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .byte_out    (byte_out),
        .byte_valid  (byte_valid),
        .error_flag  (error_flag),
        .error_code  (error_code),
        .string_done (string_done)
    );

endmodule
